FILE: rtl/core/bgf_pkg.sv
// Shared types and constants of the balanced grid factorizer.
package bgf_pkg;

  // Width of the count and dimension fields on the ports.
  localparam int unsigned FIELD_W = 16;

  // The only even prime, and the first odd trial divisor.
  localparam int unsigned PRIME_TWO = 2;
  localparam int unsigned FIRST_ODD = 3;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TWOS   = 9'b000000010,
    ST_CHECK  = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_DIVEND = 9'b000010000,
    ST_LAST   = 9'b000100000,
    ST_GRID   = 9'b001000000,
    ST_MUL    = 9'b010000000,
    ST_FINISH = 9'b100000000
  } bgf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new count
    logic twos_step;  // halve the remainder and store a two
    logic div_start;  // start dividing the remainder by the trial divisor
    logic div_step;   // one quotient bit of the divider
    logic div_take;   // divisor divides: keep quotient, store divisor, divide again
    logic next_div;   // move on to the next odd divisor
    logic store_rem;  // store the leftover remainder as a prime
    logic rd_issue;   // read the top stored prime
    logic mul_step;   // multiply that prime into the smaller dimension
    logic out_load;   // copy the dimensions into the output register
  } bgf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;   // count below two
    logic rem_even;    // remainder is even
    logic loop_go;     // remainder above one and (d-1)^2 < count
    logic div_last;    // divider is on its last bit
    logic divisible;   // divider left no remainder
    logic rem_not_one; // remainder is not one
    logic idx_zero;    // no stored primes left to place
  } bgf_status_t;

endpackage

FILE: rtl/core/bgf_datapath.sv
// Datapath: count registers, bit-serial divider, prime store and grid multiplier.
module bgf_datapath #(
  parameter int COUNT_WIDTH = 16,
  parameter int MAX_PRIMES  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bgf_pkg::bgf_cmd_t             cmd,
  output bgf_pkg::bgf_status_t          status,
  input  logic [bgf_pkg::FIELD_W-1:0]   in_count,
  output logic [bgf_pkg::FIELD_W-1:0]   out_x,
  output logic [bgf_pkg::FIELD_W-1:0]   out_y
);

  localparam int CNT_W = (COUNT_WIDTH < int'(bgf_pkg::FIELD_W)) ?
                         COUNT_WIDTH : int'(bgf_pkg::FIELD_W);
  localparam int DW    = CNT_W + 1;
  localparam int SQ_W  = 2 * CNT_W + 2;
  localparam int PC_W  = $clog2(MAX_PRIMES + 1);
  localparam int IDX_W = $clog2(MAX_PRIMES);
  localparam int BC_W  = $clog2(CNT_W);
  localparam int FIRST_SQ = (int'(bgf_pkg::FIRST_ODD) - 1) * (int'(bgf_pkg::FIRST_ODD) - 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]    div_r, div_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [DW-1:0]    part_r, part_nxt;
  logic [CNT_W-1:0] shq_r, shq_nxt;
  logic [BC_W-1:0]  bit_r, bit_nxt;
  logic [PC_W-1:0]  pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0] dx_r, dx_nxt;
  logic [CNT_W-1:0] dy_r, dy_nxt;
  logic [CNT_W-1:0] rd_data_r;
  logic [bgf_pkg::FIELD_W-1:0] out_x_r, out_y_r;

  logic [CNT_W-1:0] prime_mem [MAX_PRIMES];

  logic [DW:0]        part_sh;
  logic               fits;
  logic [DW:0]        part_sub;
  logic               wr_en;
  logic               room;
  logic [CNT_W-1:0]   wr_data;
  logic [PC_W-1:0]    rd_idx_full;
  logic [IDX_W-1:0]   rd_idx;
  logic [2*CNT_W-1:0] prod;
  logic               x_smaller;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign part_sh  = {part_r, shq_r[CNT_W-1]};
  assign fits     = part_sh >= {1'b0, div_r};
  assign part_sub = part_sh - {1'b0, div_r};

  // Prime store write port and room check.
  assign wr_en = cmd.twos_step | cmd.div_take | cmd.store_rem;
  assign room  = pcnt_r < PC_W'(MAX_PRIMES);
  always_comb begin
    if (cmd.twos_step) begin
      wr_data = CNT_W'(bgf_pkg::PRIME_TWO);
    end else if (cmd.div_take) begin
      wr_data = div_r[CNT_W-1:0];
    end else begin
      wr_data = rem_r;
    end
  end

  assign rd_idx_full = pcnt_r - PC_W'(1);
  assign rd_idx      = rd_idx_full[IDX_W-1:0];

  // Grid multiplier: the prime goes into the smaller side, the second on a tie.
  assign x_smaller = dx_r < dy_r;
  assign prod      = (x_smaller ? dx_r : dy_r) * rd_data_r;

  // Next values of the datapath registers.
  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    sq_nxt   = sq_r;
    part_nxt = part_r;
    shq_nxt  = shq_r;
    bit_nxt  = bit_r;
    pcnt_nxt = pcnt_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    if (cmd.load) begin
      cnt_nxt  = CNT_W'(in_count);
      rem_nxt  = CNT_W'(in_count);
      div_nxt  = DW'(bgf_pkg::FIRST_ODD);
      sq_nxt   = SQ_W'(FIRST_SQ);
      pcnt_nxt = '0;
      dx_nxt   = CNT_W'(1);
      dy_nxt   = CNT_W'(1);
    end
    if (cmd.twos_step) begin
      rem_nxt = rem_r >> 1;
    end
    if (cmd.div_start) begin
      part_nxt = '0;
      shq_nxt  = rem_r;
      bit_nxt  = '0;
    end
    if (cmd.div_step) begin
      part_nxt = fits ? part_sub[DW-1:0] : part_sh[DW-1:0];
      shq_nxt  = {shq_r[CNT_W-2:0], fits};
      bit_nxt  = bit_r + BC_W'(1);
    end
    if (cmd.div_take) begin
      // The quotient becomes the new remainder and is divided again.
      rem_nxt  = shq_r;
      part_nxt = '0;
      shq_nxt  = shq_r;
      bit_nxt  = '0;
    end
    if (cmd.next_div) begin
      // (d+1)^2 = (d-1)^2 + 4d
      div_nxt = div_r + DW'(2);
      sq_nxt  = sq_r + SQ_W'({div_r, 2'b00});
    end
    if (wr_en && room) begin
      pcnt_nxt = pcnt_r + PC_W'(1);
    end
    if (cmd.mul_step) begin
      pcnt_nxt = pcnt_r - PC_W'(1);
      if (x_smaller) begin
        dx_nxt = prod[CNT_W-1:0];
      end else begin
        dy_nxt = prod[CNT_W-1:0];
      end
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
      bit_r  <= '0;
    end else begin
      pcnt_r <= pcnt_nxt;
      bit_r  <= bit_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    sq_r   <= sq_nxt;
    part_r <= part_nxt;
    shq_r  <= shq_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    if (cmd.out_load) begin
      out_x_r <= bgf_pkg::FIELD_W'(dx_r);
      out_y_r <= bgf_pkg::FIELD_W'(dy_r);
    end
  end

  // Prime store, written in ascending order and read back from the top.
  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      prime_mem[pcnt_r[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= prime_mem[rd_idx];
    end
  end

  // Status to the controller.
  always_comb begin
    status.below_two   = cnt_r < CNT_W'(2);
    status.rem_even    = ~rem_r[0];
    status.loop_go     = (rem_r > CNT_W'(1)) && (sq_r < SQ_W'(cnt_r));
    status.div_last    = bit_r == BC_W'(CNT_W - 1);
    status.divisible   = part_r == '0;
    status.rem_not_one = rem_r != CNT_W'(1);
    status.idx_zero    = pcnt_r == '0;
  end

  assign out_x = out_x_r;
  assign out_y = out_y_r;

endmodule

FILE: rtl/core/bgf_ctrl.sv
// Controller: sequences factoring, grid building and the item handshakes.
module bgf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bgf_pkg::bgf_cmd_t    cmd,
  input  bgf_pkg::bgf_status_t status
);

  bgf_pkg::bgf_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == bgf_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bgf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bgf_pkg::ST_TWOS;
        end
      end
      bgf_pkg::ST_TWOS: begin
        if (status.below_two) begin
          state_nxt = bgf_pkg::ST_GRID;
        end else if (status.rem_even) begin
          cmd.twos_step = 1'b1;
        end else begin
          state_nxt = bgf_pkg::ST_CHECK;
        end
      end
      bgf_pkg::ST_CHECK: begin
        if (status.loop_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = bgf_pkg::ST_DIV;
        end else begin
          state_nxt = bgf_pkg::ST_LAST;
        end
      end
      bgf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = bgf_pkg::ST_DIVEND;
        end
      end
      bgf_pkg::ST_DIVEND: begin
        if (status.divisible) begin
          cmd.div_take = 1'b1;
          state_nxt    = bgf_pkg::ST_DIV;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = bgf_pkg::ST_CHECK;
        end
      end
      bgf_pkg::ST_LAST: begin
        cmd.store_rem = status.rem_not_one;
        state_nxt     = bgf_pkg::ST_GRID;
      end
      bgf_pkg::ST_GRID: begin
        if (status.idx_zero) begin
          state_nxt = bgf_pkg::ST_FINISH;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = bgf_pkg::ST_MUL;
        end
      end
      bgf_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = bgf_pkg::ST_GRID;
      end
      bgf_pkg::ST_FINISH: begin
        // Wait until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = bgf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bgf_pkg::ST_IDLE;
      end
    endcase
  end

  // Output item valid: set on load, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bgf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/balanced_grid_factorizer.sv
// Top level of the balanced grid factorizer: controller plus datapath.
//
//   Channel | Ports                                  | Carries
//   --------+----------------------------------------+---------------------------
//   in      | in_valid, in_ready, in_process_count   | one process count per item
//   out     | out_valid, out_ready, out_dims_x/_y    | one grid per item
//
// Processing time of an item grows with the count width, the stored primes, the
// factors of two, the odd divisors tried and the odd factors found; counts below
// two skip the factoring. The divider produces one quotient bit per cycle.
// Reset is synchronous and active low; there is no clearing pass.
// A new item is taken once the last one sits in the output register; a stalled
// output holds only the final copy step.
module balanced_grid_factorizer #(
  parameter int COUNT_WIDTH = 16,
  parameter int MAX_PRIMES  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bgf_pkg::FIELD_W-1:0] in_process_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bgf_pkg::FIELD_W-1:0] out_dims_x,
  output logic [bgf_pkg::FIELD_W-1:0] out_dims_y
);

  bgf_pkg::bgf_cmd_t    cmd;
  bgf_pkg::bgf_status_t status;

  bgf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  bgf_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MAX_PRIMES  (MAX_PRIMES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_count (in_process_count),
    .out_x    (out_dims_x),
    .out_y    (out_dims_y)
  );

endmodule

FILE: rtl/core/bgf_checker.sv
// Port-level checks of the balanced grid factorizer and their binding.
module bgf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bgf_pkg::FIELD_W-1:0] out_dims_x,
  input logic [bgf_pkg::FIELD_W-1:0] out_dims_y
);

  // The block works on one item at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after an item was taken");

  // A waiting result item holds its dimensions.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dims_x) && $stable(out_dims_y))
    else $error("result item changed while stalled");

  // Grid sides are never zero.
  a_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dims_x != '0 && out_dims_y != '0)
    else $error("result item has a zero dimension");

  // After reset the block is idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind balanced_grid_factorizer bgf_checker u_bgf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_dims_x (out_dims_x),
  .out_dims_y (out_dims_y)
);

FILE: verif/tb_balanced_grid_factorizer.sv
// Testbench for the balanced grid factorizer: counts checked against a grid predictor.
`timescale 1ns / 1ps

module tb_balanced_grid_factorizer;

  // Depth of the prime store in the block under test.
  localparam int unsigned PRIME_DEPTH = 16;
  // Cycles in which no item moves on either side before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 30000;
  // Long output hold-off that lets the block fill up and stall its input.
  localparam int unsigned HOLD_CYCLES = 6000;
  localparam int unsigned HOLD_AT_RESULT = 40;
  // Worst-case item time of the block, used for the final drain.
  localparam int unsigned DRAIN_CYCLES = 3000;

  // One expected grid, tagged with the count that produced it.
  typedef struct packed {
    logic [bgf_pkg::FIELD_W-1:0] count;
    logic [bgf_pkg::FIELD_W-1:0] x;
    logic [bgf_pkg::FIELD_W-1:0] y;
  } grid_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [bgf_pkg::FIELD_W-1:0] in_process_count = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bgf_pkg::FIELD_W-1:0] out_dims_x;
  logic [bgf_pkg::FIELD_W-1:0] out_dims_y;

  logic [bgf_pkg::FIELD_W-1:0] pending_counts[$];
  grid_t                       grids_expected[$];
  int unsigned                 send_idle_pct = 15;
  int unsigned                 recv_idle_pct = 58;
  int unsigned                 mismatch_count = 0;
  int unsigned                 results_seen = 0;
  int unsigned                 idle_cycles = 0;
  int unsigned                 hold_left = 0;
  logic                        hold_done = 1'b0;

  balanced_grid_factorizer #(
    .COUNT_WIDTH (16),
    .MAX_PRIMES  (PRIME_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_process_count (in_process_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dims_x       (out_dims_x),
    .out_dims_y       (out_dims_y)
  );

  // Free-running clock.
  always #10 clk = ~clk;

  // Factor the count by trial division and place the primes, largest first,
  // into the smaller side of the grid; a tie goes to the second side.
  function automatic grid_t predict_grid(logic [bgf_pkg::FIELD_W-1:0] count);
    int unsigned primes[$];
    int unsigned rest;
    int unsigned divisor;
    int unsigned side_x;
    int unsigned side_y;
    grid_t       grid;
    side_x = 1;
    side_y = 1;
    rest = count;
    if (count >= 2) begin
      while (rest % 2 == 0) begin
        rest = rest / 2;
        if (primes.size() < PRIME_DEPTH) primes.push_back(2);
      end
      divisor = 3;
      while (rest > 1 && (divisor - 1) * (divisor - 1) < count) begin
        while (rest % divisor == 0) begin
          rest = rest / divisor;
          if (primes.size() < PRIME_DEPTH) primes.push_back(divisor);
        end
        divisor = divisor + 2;
      end
      if (rest != 1 && primes.size() < PRIME_DEPTH) primes.push_back(rest);
    end
    for (int i = primes.size() - 1; i >= 0; i--) begin
      if (side_x < side_y) side_x = side_x * primes[i];
      else side_y = side_y * primes[i];
    end
    grid.count = count;
    grid.x = side_x[bgf_pkg::FIELD_W-1:0];
    grid.y = side_y[bgf_pkg::FIELD_W-1:0];
    return grid;
  endfunction

  // Print one line per failure and keep the tally.
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sender: record each accepted count as an expected grid, then offer the
  // next pending count unless this cycle is chosen to idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) grids_expected.push_back(predict_grid(in_process_count));
      if (!in_valid || in_ready) begin
        if (pending_counts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_process_count <= pending_counts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each accepted grid with the oldest expectation and
  // choose the ready level for the next cycle.
  always @(posedge clk) begin
    grid_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (grids_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected grid %0d x %0d", out_dims_x, out_dims_y));
        end else begin
          want = grids_expected.pop_front();
          if (out_dims_x !== want.x)
            report_mismatch($sformatf("count %0d: dims_x %0d, expected %0d",
                                      want.count, out_dims_x, want.x));
          if (out_dims_y !== want.y)
            report_mismatch($sformatf("count %0d: dims_y %0d, expected %0d",
                                      want.count, out_dims_y, want.y));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long hold-off of the output, started after a number of results.
  always @(posedge clk) begin
    if (!hold_done && results_seen == HOLD_AT_RESULT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("tb_balanced_grid_factorizer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait until every queued count has been taken and every grid returned.
  task automatic wait_drained();
    while (pending_counts.size() != 0 || in_valid || grids_expected.size() != 0)
      @(negedge clk);
  endtask

  // Queue one random phase under the given idle rates. Most counts are small
  // so that the slow trial division stays short; some span the full range.
  task automatic run_random_phase(int unsigned n, int unsigned sidle, int unsigned ridle);
    int unsigned pick;
    @(posedge clk);
    send_idle_pct <= sidle;
    recv_idle_pct <= ridle;
    @(negedge clk);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 55)
        pending_counts.push_back(bgf_pkg::FIELD_W'($urandom_range(1023, 2)));
      else if (pick < 63)
        pending_counts.push_back(bgf_pkg::FIELD_W'($urandom_range(3, 0)));
      else if (pick < 78)
        pending_counts.push_back(
          bgf_pkg::FIELD_W'((1 << $urandom_range(15)) * $urandom_range(7, 1)));
      else
        pending_counts.push_back(bgf_pkg::FIELD_W'($urandom_range(65535)));
    end
    wait_drained();
  endtask

  // Stimulus: reset, directed counts, then three random phases.
  initial begin
    logic [bgf_pkg::FIELD_W-1:0] directed[$];
    // Below two, tiny values, full-range extremes, largest prime, the longest
    // chains of small primes, squares at the divisor bound, ties and patterns.
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd12, 16'd36,
                 16'd289, 16'd961, 16'd4093, 16'd16384, 16'd32768, 16'd49152,
                 16'd59049, 16'd63001, 16'd65025, 16'd65521, 16'd65534, 16'd65535,
                 16'h5555, 16'hAAAA};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) pending_counts.push_back(directed[i]);
    wait_drained();

    run_random_phase(40, 15, 58);
    run_random_phase(40, 58, 15);
    run_random_phase(40, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (grids_expected.size() != 0)
      report_mismatch($sformatf("%0d grids never arrived", grids_expected.size()));
    if (mismatch_count == 0) begin
      $display("tb_balanced_grid_factorizer: PASS");
    end else begin
      $display("tb_balanced_grid_factorizer: FAIL");
    end
    $finish;
  end

endmodule
